// ----- src/utc_clock_with_zone_offset_defines.svh -----
// Assertion macros shared by the checker of the UTC clock block.
// Depends on nothing; the including file supplies clock, reset and expressions.
`ifndef UTC_CLOCK_WITH_ZONE_OFFSET_DEFINES_SVH
`define UTC_CLOCK_WITH_ZONE_OFFSET_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTCZ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UTCZ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/utcz_pkg.sv -----
// Types and constants of the UTC clock block.
// Used by every module of the block; depends on nothing.
package utcz_pkg;

	typedef enum logic [1:0] {
		CMD_INIT = 2'd0,
		CMD_GET  = 2'd1,
		CMD_SET  = 2'd2,
		CMD_ZONE = 2'd3
	} cmd_t;

	localparam int CMD_BITS = 2;
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BOOT_VALID = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BOOT_SECS  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BOOT_TZ    = 2'd2;

	localparam int BOOT_BITS = 39;
	localparam int TZ_BITS = 12;
	localparam int NS_BITS = 30;
	localparam int NS_SUM_BITS = 31;
	localparam int US_BITS = 64;

	// Microseconds split as (us >> 6) / 15625, long division in 16-bit digits.
	localparam int LO_BITS = 6;
	localparam int NUM_BITS = US_BITS - LO_BITS;
	localparam int TOP_BITS = 10;
	localparam int DIGIT_BITS = 16;
	localparam int STEPS = 3;
	localparam int REM_BITS = 14;
	localparam int REM_US_BITS = REM_BITS + LO_BITS;
	localparam int QUOT_BITS = 45;
	localparam int DIGIT_V_BITS = REM_BITS + DIGIT_BITS;
	localparam int RECIP_BITS = 32;
	localparam int PROD_BITS = DIGIT_V_BITS + RECIP_BITS;
	localparam int RECIP_SHIFT = 45;

	localparam logic [REM_BITS-1:0]   US_DIV_ODD = 14'd15625;
	localparam logic [RECIP_BITS-1:0] US_DIV_RECIP = 32'd2251799814;

	localparam logic [BOOT_BITS-1:0]   DEFAULT_BOOT_SECONDS = 39'd43200;
	localparam logic [9:0]             NS_PER_US = 10'd1000;
	localparam logic [NS_SUM_BITS-1:0] NS_PER_SEC = 31'd1000000000;
	localparam logic [NS_SUM_BITS-1:0] NS_TWO_SEC = 31'd2000000000;

	typedef struct packed {
		logic [NUM_BITS-1:0] num;
		logic [REM_BITS-1:0] rem;
		logic [LO_BITS-1:0]  lo;
		logic [NS_BITS-1:0]  base_ns;
	} div_beat_t;

endpackage

// ----- src/utcz_state.sv -----
// Configuration registers, clock state and command decode of the UTC clock.
// Issues one division beat per get command. Depends on utcz_pkg.
module utcz_state #(
	parameter int SECONDS_BITS = 40
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic [utcz_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [utcz_pkg::BOOT_BITS-1:0]        cfg_data,
	input  logic                                  accept,
	input  logic [utcz_pkg::CMD_BITS-1:0]         cmd,
	input  logic [utcz_pkg::US_BITS-1:0]          now_us,
	input  logic signed [SECONDS_BITS-1:0]        set_seconds,
	input  logic [utcz_pkg::NS_BITS-1:0]          set_nanoseconds,
	input  logic signed [utcz_pkg::TZ_BITS-1:0]   new_tz_minutes,
	output logic                                  in_ready,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output utcz_pkg::div_beat_t                   out_beat,
	output logic signed [SECONDS_BITS-1:0]        out_sec
);

	localparam int DW = ((SECONDS_BITS > utcz_pkg::BOOT_BITS) ?
		SECONDS_BITS : utcz_pkg::BOOT_BITS) + 2;

	logic                                 boot_valid_q;
	logic [utcz_pkg::BOOT_BITS-1:0]       boot_secs_q;
	logic signed [utcz_pkg::TZ_BITS-1:0]  boot_tz_q;

	logic signed [utcz_pkg::TZ_BITS-1:0]  zone_q;
	logic [utcz_pkg::BOOT_BITS-1:0]       boot_reading_q;
	logic signed [SECONDS_BITS-1:0]       base_sec_q;
	logic [utcz_pkg::NS_BITS-1:0]         base_ns_q;
	logic [utcz_pkg::US_BITS-1:0]         base_us_q;
	logic                                 owned_q;

	logic                                 valid_s1;
	utcz_pkg::div_beat_t                  beat_s1;
	logic signed [SECONDS_BITS-1:0]       sec_s1;

	utcz_pkg::cmd_t                       op;
	logic                                 is_init;
	logic [utcz_pkg::BOOT_BITS-1:0]       boot_pick;
	logic [utcz_pkg::BOOT_BITS-1:0]       boot_src;
	logic signed [utcz_pkg::TZ_BITS-1:0]  mins;
	logic signed [DW-1:0]                 smax;
	logic signed [DW-1:0]                 boot_ext;
	logic signed [DW-1:0]                 boot_c;
	logic signed [DW-1:0]                 mins_ext;
	logic signed [DW-1:0]                 offset;
	logic signed [DW-1:0]                 diff;
	logic signed [SECONDS_BITS-1:0]       derived;
	logic [utcz_pkg::US_BITS-1:0]         elapsed;
	logic                                 load_get;

	always_comb begin
		op = utcz_pkg::cmd_t'(cmd);
		is_init = (op == utcz_pkg::CMD_INIT);
		boot_pick = boot_valid_q ? boot_secs_q : utcz_pkg::DEFAULT_BOOT_SECONDS;
		boot_src = is_init ? boot_pick : boot_reading_q;
		mins = is_init ? boot_tz_q : new_tz_minutes;
		smax = {{(DW - SECONDS_BITS + 1){1'b0}}, {(SECONDS_BITS - 1){1'b1}}};
		boot_ext = {{(DW - utcz_pkg::BOOT_BITS){1'b0}}, boot_src};
		boot_c = (boot_ext > smax) ? smax : boot_ext;
		mins_ext = {{(DW - utcz_pkg::TZ_BITS){mins[utcz_pkg::TZ_BITS-1]}}, mins};
		offset = (mins_ext <<< 6) - (mins_ext <<< 2);
		diff = boot_c - offset;
		derived = (diff > smax) ? smax[SECONDS_BITS-1:0] : diff[SECONDS_BITS-1:0];
		elapsed = now_us - base_us_q;
		load_get = accept && (op == utcz_pkg::CMD_GET);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_valid_q <= 1'b0;
			boot_secs_q <= '0;
			boot_tz_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				utcz_pkg::CFG_BOOT_VALID: boot_valid_q <= cfg_data[0];
				utcz_pkg::CFG_BOOT_SECS:  boot_secs_q <= cfg_data;
				utcz_pkg::CFG_BOOT_TZ:    boot_tz_q <= cfg_data[utcz_pkg::TZ_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= '0;
			boot_reading_q <= '0;
			base_sec_q <= '0;
			base_ns_q <= '0;
			base_us_q <= '0;
			owned_q <= 1'b0;
		end else if (accept) begin
			case (op)
				utcz_pkg::CMD_INIT: begin
					boot_reading_q <= boot_pick;
					zone_q <= boot_tz_q;
					base_sec_q <= derived;
					base_ns_q <= '0;
					base_us_q <= now_us;
				end
				utcz_pkg::CMD_GET: ;
				utcz_pkg::CMD_SET: begin
					base_sec_q <= set_seconds;
					base_ns_q <= set_nanoseconds;
					base_us_q <= now_us;
					owned_q <= 1'b1;
				end
				utcz_pkg::CMD_ZONE: begin
					if (new_tz_minutes != zone_q) begin
						zone_q <= new_tz_minutes;
						if (!owned_q) begin
							base_sec_q <= derived;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= load_get;
		end
	end

	always_ff @(posedge clk) begin
		if (load_get && in_ready) begin
			beat_s1.num <= {{utcz_pkg::TOP_BITS{1'b0}},
				elapsed[utcz_pkg::US_BITS-utcz_pkg::TOP_BITS-1:utcz_pkg::LO_BITS]};
			beat_s1.rem <= {{(utcz_pkg::REM_BITS - utcz_pkg::TOP_BITS){1'b0}},
				elapsed[utcz_pkg::US_BITS-1:utcz_pkg::US_BITS-utcz_pkg::TOP_BITS]};
			beat_s1.lo <= elapsed[utcz_pkg::LO_BITS-1:0];
			beat_s1.base_ns <= base_ns_q;
			sec_s1 <= base_sec_q;
		end
	end

	assign out_valid = valid_s1;
	assign out_beat = beat_s1;
	assign out_sec = sec_s1;

endmodule

// ----- src/utcz_div_step.sv -----
// One 16-bit digit of the long division of elapsed microseconds by 15625.
// Two stages: reciprocal multiply, then remainder. Depends on utcz_pkg.
module utcz_div_step #(
	parameter int SECONDS_BITS = 40,
	parameter int STEP = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  utcz_pkg::div_beat_t            in_beat,
	input  logic signed [SECONDS_BITS-1:0] in_sec,
	output logic                           out_valid,
	input  logic                           out_ready,
	output utcz_pkg::div_beat_t            out_beat,
	output logic signed [SECONDS_BITS-1:0] out_sec
);

	localparam int LSB = utcz_pkg::NUM_BITS - utcz_pkg::TOP_BITS -
		(STEP + 1) * utcz_pkg::DIGIT_BITS;

	logic                                    valid_s1;
	logic                                    valid_s2;
	logic                                    ready_s1;
	logic                                    ready_s2;
	utcz_pkg::div_beat_t                     beat_s1;
	utcz_pkg::div_beat_t                     beat_s2;
	logic signed [SECONDS_BITS-1:0]          sec_s1;
	logic signed [SECONDS_BITS-1:0]          sec_s2;
	logic [utcz_pkg::DIGIT_BITS-1:0]         quo_s1;
	logic [utcz_pkg::REM_BITS-1:0]           vlo_s1;

	logic [utcz_pkg::DIGIT_V_BITS-1:0]       digit_v;
	logic [utcz_pkg::PROD_BITS-1:0]          prod;
	logic [utcz_pkg::DIGIT_V_BITS-1:0]       qd;
	utcz_pkg::div_beat_t                     beat_next;

	always_comb begin
		digit_v = {in_beat.rem, in_beat.num[LSB +: utcz_pkg::DIGIT_BITS]};
		prod = {{utcz_pkg::RECIP_BITS{1'b0}}, digit_v} *
			{{utcz_pkg::DIGIT_V_BITS{1'b0}}, utcz_pkg::US_DIV_RECIP};
		qd = {{utcz_pkg::REM_BITS{1'b0}}, quo_s1} *
			{{utcz_pkg::DIGIT_BITS{1'b0}}, utcz_pkg::US_DIV_ODD};
		beat_next = beat_s1;
		beat_next.num[LSB +: utcz_pkg::DIGIT_BITS] = quo_s1;
		beat_next.rem = vlo_s1 - qd[utcz_pkg::REM_BITS-1:0];
	end

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			beat_s1 <= in_beat;
			sec_s1 <= in_sec;
			quo_s1 <= prod[utcz_pkg::RECIP_SHIFT +: utcz_pkg::DIGIT_BITS];
			vlo_s1 <= digit_v[utcz_pkg::REM_BITS-1:0];
		end
		if (ready_s2 && valid_s1) begin
			beat_s2 <= beat_next;
			sec_s2 <= sec_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_beat = beat_s2;
	assign out_sec = sec_s2;

endmodule

// ----- src/utcz_result.sv -----
// Nanosecond carry, seconds saturation and the output register of the clock.
// Takes the finished division beat. Depends on utcz_pkg.
module utcz_result #(
	parameter int SECONDS_BITS = 40
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  utcz_pkg::div_beat_t            in_beat,
	input  logic signed [SECONDS_BITS-1:0] in_sec,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SECONDS_BITS-1:0] utc_seconds,
	output logic [utcz_pkg::NS_BITS-1:0]   utc_nanoseconds
);

	localparam int SW = ((SECONDS_BITS > utcz_pkg::QUOT_BITS + 1) ?
		SECONDS_BITS : utcz_pkg::QUOT_BITS + 1) + 1;

	logic                                  valid_s1;
	logic                                  ready_s1;
	logic                                  ready_out;
	logic [utcz_pkg::NS_SUM_BITS-1:0]      ns_s1;
	logic [utcz_pkg::QUOT_BITS-1:0]        quo_s1;
	logic signed [SECONDS_BITS-1:0]        sec_s1;
	logic                                  out_valid_q;
	logic signed [SECONDS_BITS-1:0]        out_sec_q;
	logic [utcz_pkg::NS_BITS-1:0]          out_ns_q;

	logic [utcz_pkg::REM_US_BITS-1:0]      rem_us;
	logic [utcz_pkg::NS_SUM_BITS-1:0]      ns_sum;
	logic [1:0]                            carry;
	logic [utcz_pkg::NS_SUM_BITS-1:0]      ns_mod;
	logic [utcz_pkg::QUOT_BITS:0]          whole;
	logic signed [SW-1:0]                  smax;
	logic signed [SW-1:0]                  sum;
	logic signed [SECONDS_BITS-1:0]        sec_sat;

	always_comb begin
		rem_us = {in_beat.rem, in_beat.lo};
		ns_sum = {1'b0, in_beat.base_ns} +
			({{(utcz_pkg::NS_SUM_BITS - utcz_pkg::REM_US_BITS){1'b0}}, rem_us} *
			{{(utcz_pkg::NS_SUM_BITS - 10){1'b0}}, utcz_pkg::NS_PER_US});
		if (ns_s1 >= utcz_pkg::NS_TWO_SEC) begin
			carry = 2'd2;
			ns_mod = ns_s1 - utcz_pkg::NS_TWO_SEC;
		end else if (ns_s1 >= utcz_pkg::NS_PER_SEC) begin
			carry = 2'd1;
			ns_mod = ns_s1 - utcz_pkg::NS_PER_SEC;
		end else begin
			carry = 2'd0;
			ns_mod = ns_s1;
		end
		whole = {1'b0, quo_s1} + {{(utcz_pkg::QUOT_BITS - 1){1'b0}}, carry};
		smax = {{(SW - SECONDS_BITS + 1){1'b0}}, {(SECONDS_BITS - 1){1'b1}}};
		sum = {{(SW - SECONDS_BITS){sec_s1[SECONDS_BITS-1]}}, sec_s1} +
			{{(SW - utcz_pkg::QUOT_BITS - 1){1'b0}}, whole};
		sec_sat = (sum > smax) ? smax[SECONDS_BITS-1:0] : sum[SECONDS_BITS-1:0];
	end

	assign ready_out = !out_valid_q || !out_stall;
	assign ready_s1 = !valid_s1 || ready_out;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_out) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			ns_s1 <= ns_sum;
			quo_s1 <= in_beat.num[utcz_pkg::QUOT_BITS-1:0];
			sec_s1 <= in_sec;
		end
		if (ready_out && valid_s1) begin
			out_sec_q <= sec_sat;
			out_ns_q <= ns_mod[utcz_pkg::NS_BITS-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign utc_seconds = out_sec_q;
	assign utc_nanoseconds = out_ns_q;

endmodule

// ----- src/utc_clock_with_zone_offset.sv -----
// UTC wall clock anchored to a free-running microsecond count.
// Depends on utcz_pkg, utcz_state, utcz_div_step and utcz_result.
//
// Input channel (in_valid / in_stall) carries one command beat: init,
// get time, set time or set zone offset, with the current microsecond
// count. Only get time produces a beat on the output channel
// (out_valid / out_stall) with UTC seconds and nanoseconds.
// Configuration (cfg_valid / cfg_ready, always ready) writes the boot
// time valid flag, boot local seconds and boot zone offset by index.
// Init, set and zone commands take effect at the accepting edge, so the
// next beat already sees the new clock state.
// Throughput: one beat per cycle while out_stall is low; the division of
// the elapsed count runs as three pipelined 16-bit digits, each a 30x32
// multiply. Reset clears the configuration and clock state to zero and
// empties the pipeline. While the receiver stalls, results queue in the
// pipeline stages (up to nine); in_stall rises only once all of them are
// full.
module utc_clock_with_zone_offset #(
	parameter int SECONDS_BITS = 40
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [utcz_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [utcz_pkg::BOOT_BITS-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [utcz_pkg::CMD_BITS-1:0]       cmd,
	input  logic [utcz_pkg::US_BITS-1:0]        now_us,
	input  logic signed [SECONDS_BITS-1:0]      set_seconds,
	input  logic [utcz_pkg::NS_BITS-1:0]        set_nanoseconds,
	input  logic signed [utcz_pkg::TZ_BITS-1:0] new_tz_minutes,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SECONDS_BITS-1:0]      utc_seconds,
	output logic [utcz_pkg::NS_BITS-1:0]        utc_nanoseconds
);

	localparam int NS = utcz_pkg::STEPS;

	logic                           accept;
	logic                           in_ready;
	logic [NS:0]                    vld;
	logic [NS:0]                    rdy;
	utcz_pkg::div_beat_t            beat [0:NS];
	logic signed [SECONDS_BITS-1:0] sec  [0:NS];

	assign cfg_ready = 1'b1;
	assign in_stall = !in_ready;
	assign accept = in_valid && in_ready;

	utcz_state #(
		.SECONDS_BITS(SECONDS_BITS)
	) u_state (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.accept          (accept),
		.cmd             (cmd),
		.now_us          (now_us),
		.set_seconds     (set_seconds),
		.set_nanoseconds (set_nanoseconds),
		.new_tz_minutes  (new_tz_minutes),
		.in_ready        (in_ready),
		.out_valid       (vld[0]),
		.out_ready       (rdy[0]),
		.out_beat        (beat[0]),
		.out_sec         (sec[0])
	);

	for (genvar g = 0; g < NS; g++) begin : g_step
		utcz_div_step #(
			.SECONDS_BITS(SECONDS_BITS),
			.STEP(g)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[g]),
			.in_ready  (rdy[g]),
			.in_beat   (beat[g]),
			.in_sec    (sec[g]),
			.out_valid (vld[g+1]),
			.out_ready (rdy[g+1]),
			.out_beat  (beat[g+1]),
			.out_sec   (sec[g+1])
		);
	end

	utcz_result #(
		.SECONDS_BITS(SECONDS_BITS)
	) u_result (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (vld[NS]),
		.in_ready        (rdy[NS]),
		.in_beat         (beat[NS]),
		.in_sec          (sec[NS]),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.utc_seconds     (utc_seconds),
		.utc_nanoseconds (utc_nanoseconds)
	);

endmodule

// ----- src/utcz_checker.sv -----
// Port-level checks of the UTC clock and the bind that attaches them.
// Depends on utcz_pkg and utc_clock_with_zone_offset_defines.svh.
`include "utc_clock_with_zone_offset_defines.svh"

module utcz_checker #(
	parameter int SECONDS_BITS = 40
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [SECONDS_BITS-1:0]    utc_seconds,
	input logic [utcz_pkg::NS_BITS-1:0]      utc_nanoseconds
);

	logic                                    held;
	logic [utcz_pkg::NS_SUM_BITS-1:0]        ns_wide;

	assign held = out_valid && out_stall;
	assign ns_wide = {1'b0, utc_nanoseconds};

	`UTCZ_ASSERT_NEXT(a_out_hold, clk, arst_n, held,
		out_valid && $stable(utc_seconds) && $stable(utc_nanoseconds),
		"stalled result beat changed")
	`UTCZ_ASSERT_SAME(a_ns_range, clk, arst_n, out_valid,
		ns_wide < utcz_pkg::NS_PER_SEC, "nanoseconds out of range")
	`UTCZ_ASSERT_SAME(a_stall_cause, clk, arst_n, in_stall, held,
		"input stalled while output free")

endmodule

bind utc_clock_with_zone_offset utcz_checker #(
	.SECONDS_BITS(SECONDS_BITS)
) u_utcz_checker (.*);

// ----- tb/sv/tb.sv -----
// Self-checking bench for utc_clock_with_zone_offset: drives command beats and
// register writes, predicts every UTC reading in step and compares each field.
// Depends on utcz_pkg and the RTL of the block only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import utcz_pkg::*;

	localparam int SEC_BITS = 40;
	localparam longint SEC_HI = (longint'(1) <<< (SEC_BITS - 1)) - 1;
	localparam longint SEC_LO = -SEC_HI - 1;
	localparam longint NS_WRAP = 1000000000;
	localparam longint NO_BOOT_SECS = 43200;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES = 80;
	localparam int CYCLE_LIMIT = 400000;
	localparam int BOOTS_PER_PHASE = 3;
	localparam int BEATS_PER_BOOT = 150;

	typedef struct {
		cmd_t                         op;
		logic [US_BITS-1:0]           now;
		logic signed [SEC_BITS-1:0]   secs;
		logic [NS_BITS-1:0]           nsec;
		logic signed [TZ_BITS-1:0]    tz;
	} clock_cmd_t;

	typedef struct {
		logic signed [SEC_BITS-1:0] secs;
		logic [NS_BITS-1:0]         nsec;
	} utc_time_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [BOOT_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CMD_BITS-1:0] cmd = '0;
	logic [US_BITS-1:0] now_us = '0;
	logic signed [SEC_BITS-1:0] set_seconds = '0;
	logic [NS_BITS-1:0] set_nanoseconds = '0;
	logic signed [TZ_BITS-1:0] new_tz_minutes = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SEC_BITS-1:0] utc_seconds;
	logic [NS_BITS-1:0] utc_nanoseconds;

	// predicted clock state and boot registers
	bit cfg_boot_valid;
	bit [BOOT_BITS-1:0] cfg_boot_secs;
	bit [TZ_BITS-1:0] cfg_boot_tz;
	longint zone_min;
	longint boot_secs_latched;
	longint base_secs;
	longint base_nsec;
	bit [US_BITS-1:0] base_us;
	bit owned;

	utc_time_t expected_times[$];
	bit [US_BITS-1:0] now_track;
	int send_idle_pct;
	int recv_idle_pct;
	int holds_asked;
	int holds_served;
	int hold_left;
	int cycle_count;
	int cmds_sent;
	int cfg_writes;
	int times_checked;
	int mismatches;

	utc_clock_with_zone_offset #(.SECONDS_BITS(SEC_BITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.now_us(now_us),
		.set_seconds(set_seconds),
		.set_nanoseconds(set_nanoseconds),
		.new_tz_minutes(new_tz_minutes),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.utc_seconds(utc_seconds),
		.utc_nanoseconds(utc_nanoseconds)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb: failure");
			$finish;
		end
	end

	function automatic longint clamp_secs(longint v);
		if (v > SEC_HI)
			return SEC_HI;
		if (v < SEC_LO)
			return SEC_LO;
		return v;
	endfunction

	function automatic longint add_secs_sat(longint a, longint b);
		if (b > 0 && a > SEC_HI - b)
			return SEC_HI;
		if (b < 0 && a < SEC_LO - b)
			return SEC_LO;
		return a + b;
	endfunction

	function automatic longint zone_base(longint minutes);
		return clamp_secs(add_secs_sat(clamp_secs(boot_secs_latched), -(minutes * 60)));
	endfunction

	function automatic void advance_clock(clock_cmd_t c);
		bit [US_BITS-1:0] us;
		longint ns_sum;
		longint whole;
		utc_time_t t;
		case (c.op)
			CMD_INIT: begin
				boot_secs_latched = cfg_boot_valid ? longint'(cfg_boot_secs) : NO_BOOT_SECS;
				zone_min = longint'($signed(cfg_boot_tz));
				base_secs = zone_base(zone_min);
				base_nsec = 0;
				base_us = c.now;
			end
			CMD_GET: begin
				us = c.now - base_us;
				ns_sum = base_nsec + longint'(us % 64'd1000000) * 1000;
				whole = longint'(us / 64'd1000000) + ns_sum / NS_WRAP;
				t.secs = SEC_BITS'(add_secs_sat(clamp_secs(base_secs), whole));
				t.nsec = NS_BITS'(ns_sum % NS_WRAP);
				expected_times.push_back(t);
			end
			CMD_SET: begin
				base_secs = clamp_secs(longint'(c.secs));
				base_nsec = longint'(c.nsec);
				base_us = c.now;
				owned = 1'b1;
			end
			default: begin
				if (longint'(c.tz) != zone_min) begin
					zone_min = longint'(c.tz);
					if (!owned)
						base_secs = zone_base(zone_min);
				end
			end
		endcase
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		utc_time_t want;
		if (arst_n && out_valid && !out_stall) begin
			times_checked++;
			if (expected_times.size() == 0) begin
				report_mismatch($sformatf("unexpected reading %0d s %0d ns",
					utc_seconds, utc_nanoseconds));
			end else begin
				want = expected_times.pop_front();
				if (utc_seconds !== want.secs || utc_nanoseconds !== want.nsec)
					report_mismatch($sformatf("seconds %0d (want %0d), ns %0d (want %0d)",
						utc_seconds, want.secs, utc_nanoseconds, want.nsec));
			end
		end
	end

	// receiver: long hold-off when asked, random stall otherwise
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (holds_served != holds_asked) begin
			holds_served = holds_asked;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic send_cmd(clock_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c.op;
		now_us <= c.now;
		set_seconds <= c.secs;
		set_nanoseconds <= c.nsec;
		new_tz_minutes <= c.tz;
		do @(posedge clk); while (in_stall);
		advance_clock(c);
		cmds_sent++;
	endtask

	task automatic send_op(cmd_t op, logic [US_BITS-1:0] now,
			logic signed [SEC_BITS-1:0] secs = '0, logic [NS_BITS-1:0] nsec = '0,
			logic signed [TZ_BITS-1:0] tz = '0);
		clock_cmd_t c;
		c.op = op;
		c.now = now;
		c.secs = secs;
		c.nsec = nsec;
		c.tz = tz;
		send_cmd(c);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_times.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [BOOT_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_BOOT_VALID: cfg_boot_valid = data[0];
			CFG_BOOT_SECS: cfg_boot_secs = data;
			CFG_BOOT_TZ: cfg_boot_tz = data[TZ_BITS-1:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic program_boot(bit valid, logic [BOOT_BITS-1:0] secs,
			logic signed [TZ_BITS-1:0] tz);
		wait_drained();
		write_reg(CFG_BOOT_VALID, BOOT_BITS'(valid));
		write_reg(CFG_BOOT_SECS, secs);
		write_reg(CFG_BOOT_TZ, BOOT_BITS'(tz));
		cfg_valid <= 1'b0;
	endtask

	task automatic program_random_boot();
		logic [63:0] r64;
		logic [BOOT_BITS-1:0] secs;
		r64 = {$urandom, $urandom};
		case ($urandom_range(3))
			0: secs = r64[BOOT_BITS-1:0];
			1: secs = BOOT_BITS'(1_600_000_000 + longint'(r64[27:0]));
			2: secs = {BOOT_BITS{1'b1}} - BOOT_BITS'(r64[15:0]);
			default: secs = BOOT_BITS'(r64[15:0]);
		endcase
		program_boot(1'($urandom_range(1)), secs, TZ_BITS'(int'($urandom_range(2878)) - 1439));
	endtask

	function automatic clock_cmd_t random_cmd(bit allow_set);
		clock_cmd_t c;
		int pick;
		logic [63:0] r64;
		r64 = {$urandom, $urandom};
		pick = $urandom_range(99);
		// mostly a counter moving forward; now and then a jump, a wild value or a step back
		if (pick < 85)
			now_track += 64'($urandom_range(3_000_000));
		else if (pick < 92)
			now_track += 64'($urandom) * 64'd1000;
		else if (pick < 96)
			now_track = r64;
		else
			now_track -= 64'($urandom_range(1_000_000, 1));
		c.now = now_track;
		pick = $urandom_range(99);
		c.op = (pick < 45) ? CMD_GET : (pick < 60) ? CMD_INIT : (pick < 80) ? CMD_ZONE :
			(allow_set ? CMD_SET : CMD_GET);
		r64 = {$urandom, $urandom};
		pick = $urandom_range(9);
		if (pick < 4)
			c.secs = r64[SEC_BITS-1:0];
		else if (pick < 8)
			c.secs = SEC_BITS'(1_700_000_000 + longint'(r64[29:0]));
		else if (pick == 8)
			c.secs = SEC_BITS'(SEC_HI - longint'(r64[7:0]));
		else
			c.secs = SEC_BITS'(SEC_LO + longint'(r64[7:0]));
		c.nsec = ($urandom_range(9) == 0) ?
			NS_BITS'($urandom_range(30'h3FFF_FFFF, 1_000_000_000)) :
			NS_BITS'($urandom_range(999_999_999));
		c.tz = ($urandom_range(4) == 0) ? TZ_BITS'(zone_min) :
			TZ_BITS'(int'($urandom_range(2878)) - 1439);
		return c;
	endfunction

	// clock never set by a program: zone changes re-derive the base
	task automatic test_unowned_corners();
		send_op(CMD_GET, 64'd0);
		send_op(CMD_GET, '1);
		send_op(CMD_ZONE, 64'd0, '0, '0, -12'sd1439);
		send_op(CMD_ZONE, 64'd5, '0, '0, -12'sd1439);
		send_op(CMD_GET, 64'd1_500_000);
		send_op(CMD_INIT, 64'd1000);
		send_op(CMD_GET, 64'd1000);
		send_op(CMD_GET, 64'd999);
		send_op(CMD_ZONE, 64'd0, '0, '0, 12'sd1439);
		send_op(CMD_GET, 64'd2_000_999);
		program_boot(1'b1, '1, -12'sd1439);
		send_op(CMD_INIT, 64'd5);
		send_op(CMD_GET, 64'd5);
		send_op(CMD_ZONE, 64'd0, '0, '0, 12'sd1439);
		send_op(CMD_GET, 64'd6);
		program_boot(1'b1, '0, 12'sd1439);
		send_op(CMD_INIT, 64'hFFFF_FFFF_FFFF_FFF0);
		send_op(CMD_GET, 64'd16);
	endtask

	task automatic test_random_unowned();
		repeat (BOOTS_PER_PHASE) begin
			program_random_boot();
			repeat (BEATS_PER_BOOT) send_cmd(random_cmd(1'b0));
		end
	endtask

	task automatic test_owned_corners();
		program_boot(1'b1, 39'd1_700_000_000, 12'sd60);
		send_op(CMD_INIT, 64'd100);
		send_op(CMD_SET, 64'd200, SEC_BITS'(SEC_HI), 30'd999_999_999);
		send_op(CMD_GET, 64'd1_000_200);
		send_op(CMD_SET, 64'd0, SEC_BITS'(SEC_LO), 30'd0);
		send_op(CMD_GET, 64'd0);
		send_op(CMD_SET, 64'd10, '0, 30'h3FFF_FFFF);
		send_op(CMD_GET, 64'd1_000_009);
		send_op(CMD_ZONE, 64'd0, '0, '0, -12'sd600);
		send_op(CMD_INIT, 64'd50);
		send_op(CMD_GET, 64'd2_000_050);
	endtask

	task automatic test_random_mixed(int send_pct, int recv_pct);
		wait_drained();
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (BOOTS_PER_PHASE) begin
			program_random_boot();
			repeat (BEATS_PER_BOOT) send_cmd(random_cmd(1'b1));
		end
	endtask

	// hold the output long enough to back the pipeline up into the input
	task automatic test_backpressure();
		clock_cmd_t c;
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		holds_asked++;
		repeat (40) begin
			c = random_cmd(1'b1);
			c.op = CMD_GET;
			send_cmd(c);
		end
		wait_drained();
		repeat (10) send_cmd(random_cmd(1'b1));
	endtask

	initial begin
		send_idle_pct = 10;
		recv_idle_pct = 64;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unowned_corners();
		test_random_unowned();
		test_owned_corners();
		test_random_mixed(10, 64);
		test_random_mixed(64, 10);
		test_random_mixed(0, 0);
		test_backpressure();
		wait_drained();
		$display("summary: %0d command beats and %0d register writes, %0d readings checked",
			cmds_sent, cfg_writes, times_checked);
		$display("summary: %0d mismatches, %0d readings outstanding",
			mismatches, expected_times.size());
		if (mismatches == 0 && expected_times.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+src
src/utcz_pkg.sv
src/utcz_state.sv
src/utcz_div_step.sv
src/utcz_result.sv
src/utc_clock_with_zone_offset.sv
src/utcz_checker.sv
tb/sv/tb.sv
